FILE: rtl/mal_pkg.sv
// Shared types and constants of the MacCormack advection line core.
// Used by mal_ctrl, mal_datapath and the top level; depends on nothing.
`default_nettype none

package mal_pkg;

  // Field widths
  localparam int unsigned CellW  = 32;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned IdxW   = 2;

  // Internal widths: Courant number, wide intermediates, multiplier accumulator
  localparam int unsigned CourW  = 24;
  localparam int unsigned WideW  = 48;
  localparam int unsigned ChunkW = 16;
  localparam int unsigned PpW    = CourW + ChunkW + 1;
  localparam int unsigned AccW   = CourW + WideW;

  // Register indexes of the configuration port
  localparam logic [IdxW-1:0] REG_STEP_RATIO  = 2'd0;
  localparam logic [IdxW-1:0] REG_EDGE_CLAMP  = 2'd1;
  localparam logic [IdxW-1:0] REG_VALUE_FLOOR = 2'd2;

  // Register reset values
  localparam logic [CfgW-1:0] STEP_RATIO_RST  = 16'd410;
  localparam logic            EDGE_CLAMP_RST  = 1'b0;
  localparam logic [CfgW-1:0] VALUE_FLOOR_RST = 16'd1;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_C_MUL,
    OP_C_RND,
    OP_LOAD,
    OP_MUL,
    OP_PRED,
    OP_PREDL,
    OP_SET_D3,
    OP_CORR
  } dp_op_t;

  typedef struct packed {
    logic       accept;
    dp_op_t     op;
    logic       job_b;
    logic [1:0] mul_k;
  } dp_cmd_t;

  typedef struct packed {
    logic do_a;
    logic do_b;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/mal_ctrl.sv
// Controller state machine of the MacCormack advection line core.
// Sequences the datapath per request; uses mal_pkg.
`default_nettype none

module mal_ctrl
  import mal_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_C_MUL = 10'b00_0000_0010,
    ST_C_RND = 10'b00_0000_0100,
    ST_LOAD  = 10'b00_0000_1000,
    ST_P_MUL = 10'b00_0001_0000,
    ST_P_FIN = 10'b00_0010_0000,
    ST_L_MUL = 10'b00_0100_0000,
    ST_L_FIN = 10'b00_1000_0000,
    ST_R_SET = 10'b01_0000_0000,
    ST_R_MUL = 10'b10_0000_0000
  } state_t;

  // Corrector finish shares the R_MUL code space? No: keep a separate flag state.
  state_t     state, state_next;
  logic       r_fin, r_fin_next;
  logic       job_b, job_b_next;
  logic [1:0] mul_k, mul_k_next;

  assign s_tready = (state == ST_IDLE) && !r_fin;

  // Next state and commands
  always_comb begin
    state_next  = state;
    r_fin_next  = r_fin;
    job_b_next  = job_b;
    mul_k_next  = 2'd0;
    cmd.accept  = 1'b0;
    cmd.op      = OP_NONE;
    cmd.job_b   = job_b;
    cmd.mul_k   = mul_k;
    if (r_fin) begin
      // Finish the corrector once the output register is free
      if (!sts.out_busy) begin
        cmd.op     = OP_CORR;
        r_fin_next = 1'b0;
        if (!job_b && sts.do_b) begin
          job_b_next = 1'b1;
          state_next = ST_LOAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          cmd.accept = s_tvalid;
          if (s_tvalid) begin
            state_next = ST_C_MUL;
          end
        end
        ST_C_MUL: begin
          cmd.op     = OP_C_MUL;
          state_next = ST_C_RND;
        end
        ST_C_RND: begin
          cmd.op = OP_C_RND;
          if (sts.do_a) begin
            job_b_next = 1'b0;
            state_next = ST_LOAD;
          end else if (sts.do_b) begin
            job_b_next = 1'b1;
            state_next = ST_LOAD;
          end else begin
            state_next = ST_IDLE;
          end
        end
        ST_LOAD: begin
          cmd.op     = OP_LOAD;
          state_next = ST_P_MUL;
        end
        ST_P_MUL, ST_L_MUL, ST_R_MUL: begin
          cmd.op     = OP_MUL;
          mul_k_next = mul_k + 2'd1;
          if (mul_k == 2'd3) begin
            mul_k_next = 2'd0;
            if (state == ST_P_MUL) begin
              state_next = ST_P_FIN;
            end else if (state == ST_L_MUL) begin
              state_next = ST_L_FIN;
            end else begin
              r_fin_next = 1'b1;
            end
          end
        end
        ST_P_FIN: begin
          cmd.op     = OP_PRED;
          state_next = ST_L_MUL;
        end
        ST_L_FIN: begin
          cmd.op     = OP_PREDL;
          state_next = ST_R_SET;
        end
        ST_R_SET: begin
          cmd.op     = OP_SET_D3;
          state_next = ST_R_MUL;
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      r_fin <= 1'b0;
      job_b <= 1'b0;
      mul_k <= 2'd0;
    end else begin
      state <= state_next;
      r_fin <= r_fin_next;
      job_b <= job_b_next;
      mul_k <= mul_k_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mal_datapath.sv
// Datapath of the MacCormack advection line core: configuration registers,
// cell window, shared partial-product multiplier and output register. Uses mal_pkg.
`default_nettype none

module mal_datapath
  import mal_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic              cfg_valid,
  input  logic [IdxW-1:0]   cfg_index,
  input  logic [CfgW-1:0]   cfg_data,
  input  logic [CellW-1:0]  cell_value,
  input  logic [SpeedW-1:0] line_speed,
  input  logic              line_first,
  input  logic              line_last,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [CellW-1:0]  m_tdata,
  output logic              m_tlast
);

  // Configuration
  logic [CfgW-1:0] step_ratio;
  logic            edge_clamp;
  logic [CfgW-1:0] value_floor;

  // Line state
  logic [CellW-1:0]  centre_cell;
  logic [CellW-1:0]  left_cell;
  logic [1:0]        cells_seen;
  logic [SpeedW-1:0] held_speed;

  // Jobs of the current request
  logic [CellW-1:0] a_left, a_mid, x_cell, b_mid;
  logic             do_a, do_b, last_a;

  // Arithmetic
  logic signed [CellW:0]    c_prod;
  logic signed [CourW-1:0]  courant;
  logic signed [WideW-1:0]  fl, f, pred, predl, avg;
  logic signed [WideW-1:0]  mul_b;
  logic signed [PpW-1:0]    pp;
  logic signed [AccW-1:0]   acc;
  logic                     job_last;

  // Accept decode
  logic [1:0]       seen_eff;
  logic             seen0;
  logic [CellW-1:0] lv;

  assign seen_eff = line_first ? 2'd0 : cells_seen;
  assign seen0    = (seen_eff == 2'd0);
  assign lv       = (seen_eff == 2'd1) ? centre_cell : left_cell;

  // Job operand select
  logic [CellW-1:0] sel_l, sel_m, sel_r;
  assign sel_l = cmd.job_b ? b_mid  : a_left;
  assign sel_m = cmd.job_b ? x_cell : a_mid;
  assign sel_r = x_cell;

  // Multiplier chunk, top signed chunk first
  logic signed [ChunkW:0] chunk;
  always_comb begin
    case (cmd.mul_k)
      2'd0:    chunk = {mul_b[WideW-1], mul_b[WideW-1 -: ChunkW]};
      2'd1:    chunk = {1'b0, mul_b[2*ChunkW-1 -: ChunkW]};
      2'd2:    chunk = {1'b0, mul_b[ChunkW-1:0]};
      default: chunk = '0;
    endcase
  end

  // Rounding of the accumulator and Courant product
  logic signed [AccW-1:0]  acc_r16, acc_r17;
  logic signed [CellW+1:0] c_sum;
  logic signed [WideW:0]   avg_sum;
  logic signed [WideW-1:0] corr;
  logic [CellW-1:0]        result;

  assign acc_r16 = acc + AccW'(32'sd32768);
  assign acc_r17 = acc + AccW'(32'sd65536);
  assign c_sum   = {c_prod[CellW], c_prod} + (CellW+2)'(512);
  assign avg_sum = {f[WideW-1], f} + {pred[WideW-1], pred} + (WideW+1)'(1);
  assign corr    = avg - acc_r17[WideW+16:17];

  // Floor and saturate
  always_comb begin
    if (corr < $signed({{(WideW-CfgW){1'b0}}, value_floor})) begin
      result = {{(CellW-CfgW){1'b0}}, value_floor};
    end else if (corr > $signed({{(WideW-CellW){1'b0}}, {CellW{1'b1}}})) begin
      result = {CellW{1'b1}};
    end else begin
      result = corr[CellW-1:0];
    end
  end

  assign sts.do_a     = do_a;
  assign sts.do_b     = do_b;
  assign sts.out_busy = m_tvalid && !m_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio  <= STEP_RATIO_RST;
      edge_clamp  <= EDGE_CLAMP_RST;
      value_floor <= VALUE_FLOOR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STEP_RATIO:  step_ratio  <= cfg_data;
        REG_EDGE_CLAMP:  edge_clamp  <= cfg_data[0];
        REG_VALUE_FLOOR: value_floor <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window and line state: advance on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      centre_cell <= '0;
      left_cell   <= '0;
      cells_seen  <= 2'd0;
      held_speed  <= '0;
      do_a        <= 1'b0;
      do_b        <= 1'b0;
    end else if (cmd.accept) begin
      if (line_first) begin
        held_speed <= line_speed;
      end
      if (!seen0) begin
        left_cell <= centre_cell;
      end
      centre_cell <= cell_value;
      cells_seen  <= line_last ? 2'd0 : (seen0 ? 2'd1 : 2'd2);
      do_a        <= !seen0 && (seen_eff[1] || edge_clamp);
      do_b        <= edge_clamp && line_last;
    end
  end

  // Job operands of the request
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      a_left <= lv;
      a_mid  <= centre_cell;
      x_cell <= cell_value;
      b_mid  <= seen0 ? cell_value : centre_cell;
      last_a <= line_last && !edge_clamp;
    end
  end

  // Arithmetic steps
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_C_MUL: begin
        c_prod <= $signed(held_speed) * $signed({1'b0, step_ratio});
      end
      OP_C_RND: begin
        courant <= c_sum[CellW+1:10];
      end
      OP_LOAD: begin
        fl       <= $signed({{(WideW-CellW){1'b0}}, sel_l});
        f        <= $signed({{(WideW-CellW){1'b0}}, sel_m});
        mul_b    <= $signed({{(WideW-CellW){1'b0}}, sel_r})
                  - $signed({{(WideW-CellW){1'b0}}, sel_m});
        job_last <= cmd.job_b ? 1'b1 : last_a;
      end
      OP_MUL: begin
        pp <= courant * chunk;
        if (cmd.mul_k == 2'd1) begin
          acc <= AccW'(pp);
        end else if (cmd.mul_k != 2'd0) begin
          acc <= {acc[AccW-ChunkW-1:0], {ChunkW{1'b0}}} + AccW'(pp);
        end
      end
      OP_PRED: begin
        pred  <= f - acc_r16[WideW+15:16];
        mul_b <= f - fl;
      end
      OP_PREDL: begin
        predl <= fl - acc_r16[WideW+15:16];
        avg   <= avg_sum[WideW:1];
      end
      OP_SET_D3: begin
        mul_b <= pred - predl;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_CORR) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CORR) begin
      m_tdata <= result;
      m_tlast <= job_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/maccormack_advection_line_core.sv
// Top level of the MacCormack advection line core.
// Instantiates mal_ctrl and mal_datapath; uses mal_pkg.
//
// Usage:
//   Cells of one grid line enter on the s_ stream, one request per cell,
//   with s_tuser marking the first cell (its speed is latched) and s_tlast
//   the last. Updated densities leave on the m_ stream, m_tlast marking the
//   final result of a line. Registers are written on the cfg_ channel,
//   which is always ready; write it only while the core is idle.
// Sequencing:
//   One request at a time. Each result runs through one shared 24x17-bit
//   multiplier in partial-product passes, three passes per result
//   (predictor, left predictor, corrector), after the Courant number is
//   formed once per request. A request gives no result, one or two; the
//   next request is taken only once these are in the output register.
// Reset:
//   rst clears the window, the held speed and the output register and
//   restores the register defaults (step ratio 410, interior mode, floor 1).
// Stall:
//   A result waits in the output register while m_tready is low; the next
//   request may still be taken, and its first result holds in the core
//   until the register frees.
`default_nettype none

module maccormack_advection_line_core
  import mal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // cell_value [31:0], line_speed [47:32]
  input  logic        s_tuser,   // line_first
  input  logic        s_tlast,   // line_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // new_value [31:0]
  output logic        m_tlast,   // result_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  mal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mal_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cell_value  (s_tdata[31:0]),
    .line_speed  (s_tdata[47:32]),
    .line_first  (s_tuser),
    .line_last   (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/mal_checker.sv
// Port-level checks of the MacCormack advection line core, bound to the
// top level. Depends on maccormack_advection_line_core only through the bind.
`default_nettype none

module mal_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed or dropped");

  // Reset empties the output and opens the input
  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("core not idle after reset");

  // One request at a time: input closes after a request
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken back to back");

  // A new result never follows a request in the next cycle
  a_no_quick_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("result appeared right after a request");

endmodule

bind maccormack_advection_line_core mal_checker u_mal_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: bench/tb_maccormack_advection_line_core.sv
// Self-checking testbench for maccormack_advection_line_core.
// Drives cells on the s_ stream, predicts each updated density in the bench and
// checks the m_ stream against it; depends on mal_pkg and the core only.
module tb_maccormack_advection_line_core;
  import mal_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int IDLE_TAIL  = 64;    // cycles to let a request with no result finish
  localparam int LONG_HOLD  = 400;   // receiver hold-off while the sender keeps going
  localparam int STALL_MAX  = 4000;  // cycles without any accepted request
  localparam int CELL_COUNT = 950;

  typedef struct packed {
    logic [31:0] density;
    logic        line_end;
  } density_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // cell_value [31:0], line_speed [47:32]
  logic        s_tuser = 1'b0; // line_first
  logic        s_tlast = 1'b0; // line_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // new_value [31:0]
  logic        m_tlast;        // result_last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_STEP_RATIO;
  logic [15:0] cfg_data = '0;

  // Bench copy of the core: registers, window and held speed
  logic [15:0] ratio_q   = STEP_RATIO_RST;
  logic        clamp_q   = EDGE_CLAMP_RST;
  logic [15:0] floor_q   = VALUE_FLOOR_RST;
  logic [31:0] win_centre = '0;
  logic [31:0] win_left   = '0;
  int          win_count  = 0;
  logic [15:0] speed_q    = '0;

  density_t expected_densities[$];
  int       error_count   = 0;
  int       cells_sent    = 0;
  bit       idle_on       = 1'b1;
  bit       long_hold_req = 1'b0;
  int       quiet_cycles  = 0;

  maccormack_advection_line_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // x / 2^s rounded to nearest, ties toward plus infinity
  function automatic longint round_shift(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // One MacCormack step on a three-cell window, floored and saturated
  function automatic logic [31:0] advect_cell(logic [31:0] lv, logic [31:0] mv,
                                              logic [31:0] rv);
    longint c, f, fl, fr, pred, predl, avg, corr;
    c     = round_shift(longint'($signed(speed_q)) * longint'(ratio_q), 10);
    f     = longint'(mv);
    fl    = longint'(lv);
    fr    = longint'(rv);
    pred  = f - round_shift(c * (fr - f), 16);
    predl = fl - round_shift(c * (f - fl), 16);
    avg   = round_shift(f + pred, 1);
    corr  = avg - round_shift(c * (pred - predl), 17);
    if (corr < longint'(floor_q)) corr = longint'(floor_q);
    if (corr > longint'(32'hFFFF_FFFF)) corr = longint'(32'hFFFF_FFFF);
    return corr[31:0];
  endfunction

  // Advance the window on an accepted cell and queue the densities it yields
  function automatic void track_cell(logic [31:0] x, logic [15:0] spd,
                                     logic first, logic last);
    logic [31:0] lv;
    if (first) begin
      speed_q   = spd;
      win_count = 0;
    end
    if (win_count == 0) begin
      if (clamp_q && last) expected_densities.push_back({advect_cell(x, x, x), 1'b1});
      win_centre = x;
      win_count  = 1;
    end else begin
      lv = (win_count == 1) ? win_centre : win_left;
      if (win_count >= 2 || clamp_q)
        expected_densities.push_back({advect_cell(lv, win_centre, x), last && !clamp_q});
      if (clamp_q && last)
        expected_densities.push_back({advect_cell(win_centre, x, x), 1'b1});
      win_left   = win_centre;
      win_centre = x;
      win_count  = 2;
    end
    if (last) win_count = 0;
  endfunction

  // Offer one cell after a random gap; valid stays high after the handshake
  task automatic send_cell(input logic [31:0] x, input logic [15:0] spd,
                           input logic first, input logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {spd, x};
    s_tuser  <= first;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    track_cell(x, spd, first, last);
    cells_sent++;
  endtask

  task automatic stop_cells();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (expected_densities.size() != 0) @(posedge clk);
  endtask

  // Hold the sender until the core has nothing left to do
  task automatic settle_idle();
    stop_cells();
    drain_results();
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  // Write one register; valid is left high for a following write
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STEP_RATIO:  ratio_q = value;
      REG_EDGE_CLAMP:  clamp_q = value[0];
      REG_VALUE_FLOOR: floor_q = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] ratio, input logic clamp,
                                input logic [15:0] min_value);
    settle_idle();
    write_reg(REG_STEP_RATIO, ratio);
    write_reg(REG_EDGE_CLAMP, {15'd0, clamp});
    write_reg(REG_VALUE_FLOOR, min_value);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_density(logic [31:0] prev);
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 32'h0004_0000);
      3, 4, 5: return prev + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_speed();
    logic [15:0] mag;
    mag = 16'($urandom_range(0, 4096));
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return -mag;
      4:       return mag;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed lines; now and then a line with random marks
  task automatic send_random_line();
    int          len;
    bit          noisy;
    logic [31:0] x;
    logic [15:0] spd;
    logic        first, last;
    len   = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    noisy = ($urandom_range(0, 7) == 0);
    spd   = pick_speed();
    x     = $urandom;
    for (int i = 0; i < len; i++) begin
      x     = pick_density(x);
      first = (i == 0);
      last  = (i == len - 1);
      if (noisy) begin
        first = ($urandom_range(0, 5) == 0);
        last  = ($urandom_range(0, 5) == 0);
      end
      send_cell(x, first ? spd : 16'($urandom), first, last);
    end
  endtask

  task automatic test_interior_defaults();
    // Extremes with saturation and floor, then lines too short to give a result
    send_cell(32'h0000_0000, 16'h7FFF, 1'b1, 1'b0);
    send_cell(32'hFFFF_FFFF, 16'h1234, 1'b0, 1'b0);
    send_cell(32'h0000_0000, 16'h0000, 1'b0, 1'b0);
    send_cell(32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b1);
    send_cell(32'h0001_0000, 16'h8000, 1'b1, 1'b1);
    send_cell(32'h0002_0000, 16'h8000, 1'b1, 1'b0);
    send_cell(32'h0003_0000, 16'h0000, 1'b0, 1'b1);
    // Line without a first mark keeps the held speed
    send_cell(32'h8000_0000, 16'h7FFF, 1'b0, 1'b0);
    send_cell(32'h0000_0001, 16'h7FFF, 1'b0, 1'b0);
    send_cell(32'h7FFF_FFFF, 16'h7FFF, 1'b0, 1'b1);
  endtask

  task automatic test_clamp_extremes();
    apply_settings(16'hFFFF, 1'b1, 16'hFFFF);
    // Single-cell line, both neighbours are self
    send_cell(32'hFFFF_FFFF, 16'h8000, 1'b1, 1'b1);
    send_cell(32'h1234_5678, 16'h8000, 1'b1, 1'b0);
    send_cell(32'h0000_0000, 16'h0000, 1'b0, 1'b0);
    send_cell(32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b1);
    // First mark inside an open line drops it
    send_cell(32'h0010_0000, 16'h4000, 1'b1, 1'b0);
    send_cell(32'h0020_0000, 16'h0000, 1'b0, 1'b0);
    send_cell(32'h0030_0000, 16'hC000, 1'b1, 1'b0);
    send_cell(32'h0040_0000, 16'h0000, 1'b0, 1'b1);
    apply_settings(16'h0000, 1'b0, 16'h0000);
    send_cell(32'h0000_0000, 16'h7FFF, 1'b1, 1'b0);
    send_cell(32'hAAAA_5555, 16'h0000, 1'b0, 1'b0);
    send_cell(32'h5555_AAAA, 16'h0000, 1'b0, 1'b1);
  endtask

  task automatic test_random_lines(input int cells);
    int stop_at;
    stop_at = cells_sent + cells;
    while (cells_sent < stop_at) send_random_line();
  endtask

  task automatic test_output_backpressure();
    apply_settings(16'd2048, 1'b1, 16'd16);
    long_hold_req = 1'b1;
    for (int i = 0; i < 24; i++)
      send_cell($urandom, pick_speed(), i == 0, i == 23);
  endtask

  task automatic test_sender_pause();
    // Pause mid-line until every queued density is out, then resume the line
    for (int i = 0; i < 5; i++) send_cell($urandom, 16'h2000, i == 0, 1'b0);
    stop_cells();
    drain_results();
    for (int i = 0; i < 5; i++) send_cell($urandom, 16'h0000, 1'b0, i == 4);
  endtask

  // Receiver: random hold-offs per result, and one long hold on request
  initial begin
    int stall;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = idle_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready) && !long_hold_req);
    end
  end

  // Compare each accepted result with the oldest expected density
  always @(posedge clk) begin : check_results
    density_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_densities.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h last %b",
                 $time, m_tdata, m_tlast);
        error_count++;
      end else begin
        want = expected_densities.pop_front();
        if (m_tdata !== want.density) begin
          $display("%0t: new_value mismatch, expected %h, actual %h",
                   $time, want.density, m_tdata);
          error_count++;
        end
        if (m_tlast !== want.line_end) begin
          $display("%0t: result_last mismatch, expected %b, actual %b",
                   $time, want.line_end, m_tlast);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request on any channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("%0t: timeout, no request accepted for %0d cycles", $time, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_interior_defaults();
    test_clamp_extremes();
    apply_settings(STEP_RATIO_RST, EDGE_CLAMP_RST, VALUE_FLOOR_RST);
    test_random_lines(150);
    apply_settings(16'hFFFF, 1'b1, 16'hFFFF);
    test_random_lines(140);
    apply_settings(16'h0000, 1'b0, 16'h0000);
    test_random_lines(120);
    test_output_backpressure();
    test_sender_pause();
    apply_settings(16'd4096, 1'b1, 16'h0000);
    idle_on = 1'b0;
    test_random_lines(140);
    idle_on = 1'b1;
    apply_settings(16'($urandom), 1'($urandom), 16'($urandom));
    test_random_lines(140);
    apply_settings(16'($urandom_range(0, 8192)), 1'b0, 16'($urandom));
    test_random_lines(CELL_COUNT - cells_sent);
    stop_cells();
    drain_results();
    repeat (IDLE_TAIL) @(posedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
rtl/mal_pkg.sv
rtl/mal_ctrl.sv
rtl/mal_datapath.sv
rtl/maccormack_advection_line_core.sv
rtl/mal_checker.sv
bench/tb_maccormack_advection_line_core.sv
